[rtl/jsc_pkg.sv]
// ----------------------------------------------------------------------------
// jsc_pkg
// Shared types and character constants of the JSON object syntax checker.
// ----------------------------------------------------------------------------
`default_nettype none

package jsc_pkg;

    localparam logic [7:0] CHAR_OPEN  = 8'h7B;
    localparam logic [7:0] CHAR_CLOSE = 8'h7D;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_N     = 8'h6E;
    localparam logic [7:0] CHAR_U     = 8'h75;
    localparam logic [7:0] CHAR_L     = 8'h6C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5A;

    localparam int unsigned OUT_POS_BITS = 16;

    typedef enum logic [1:0] {
        VERDICT_ACCEPTED   = 2'd0,
        VERDICT_UNEXPECTED = 2'd1,
        VERDICT_EARLY_END  = 2'd2,
        VERDICT_TOO_DEEP   = 2'd3
    } verdict_t;

    typedef struct packed {
        logic is_ws;
        logic is_digit;
        logic is_alnum;
        logic is_open;
        logic is_close;
        logic is_colon;
        logic is_comma;
        logic is_quote;
        logic is_n;
        logic is_u;
        logic is_l;
    } char_class_t;

endpackage

`default_nettype wire

[rtl/json_object_syntax_checker.sv]
// ----------------------------------------------------------------------------
// json_object_syntax_checker
// Streaming syntax checker for a JSON object subset, one byte per beat.
// ----------------------------------------------------------------------------
// Bytes of a document enter on the s_ channel, one per beat; a beat with
// s_tlast high marks the end of the document, its byte is not looked at and
// the checker is rearmed for the next document. For each document exactly one
// verdict beat leaves on the m_ channel, with the byte position it refers to;
// bytes after the verdict give nothing until the end-of-document beat.
// The nesting limit is written through the cfg_ channel; the user must write
// it only while the block idles, and the block does not enforce this. An
// accepted byte is held in the input register and parsed from it into the
// registered verdict output. One byte is accepted every cycle unless a verdict
// stalls; the parse step is a single state transition with no loop behind it.
// If the receiver stalls with a verdict pending, the byte in the input register
// waits, and s_tready falls only once that register is also full.
// Reset clears the parse state and sets the nesting limit to 255.
// ----------------------------------------------------------------------------
`default_nettype none

module json_object_syntax_checker #(
    parameter int unsigned DEPTH_BITS    = 8,
    parameter int unsigned POSITION_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
    input  wire logic        s_tlast,   // end_of_input
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [1:0] verdict, [17:2] byte_position, rest zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data   // [7:0] max_nesting
);

    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            in_byte_reg,  in_byte_next;
    logic                  in_last_reg,  in_last_next;
    logic [7:0]            max_nesting_reg, max_nesting_next;
    logic                  advance;
    logic                  item_fire;
    jsc_pkg::char_class_t  char_class;
    jsc_pkg::verdict_t     verdict;
    logic [jsc_pkg::OUT_POS_BITS-1:0] byte_position;

    assign advance   = !m_tvalid || m_tready;
    assign item_fire = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next    = in_valid_reg;
        in_byte_next     = in_byte_reg;
        in_last_next     = in_last_reg;
        max_nesting_next = max_nesting_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_byte_next  = s_tdata;
            in_last_next  = s_tlast;
        end
        if (cfg_valid && cfg_ready) begin
            max_nesting_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            in_byte_reg     <= 8'd0;
            in_last_reg     <= 1'b0;
            max_nesting_reg <= 8'd255;
        end else begin
            in_valid_reg    <= in_valid_next;
            in_byte_reg     <= in_byte_next;
            in_last_reg     <= in_last_next;
            max_nesting_reg <= max_nesting_next;
        end
    end

    jsc_classify u_classify (
        .char_byte  (in_byte_reg),
        .char_class (char_class)
    );

    jsc_parser #(
        .DEPTH_BITS    (DEPTH_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_fire     (item_fire),
        .item_last     (in_last_reg),
        .char_class    (char_class),
        .max_nesting   (max_nesting_reg),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .verdict       (verdict),
        .byte_position (byte_position)
    );

    assign m_tdata = {6'd0, byte_position, verdict};

    a_stall_only_when_full: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && m_tvalid && !m_tready)
    ) else $error("input stalled while the pipeline could advance");

    a_result_from_item: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(item_fire)
    ) else $error("verdict appeared without a parsed beat");

    a_accept_counts_brace: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (verdict == jsc_pkg::VERDICT_ACCEPTED)) |-> (byte_position != '0)
    ) else $error("accepted verdict with zero byte position");

endmodule

`default_nettype wire

[rtl/jsc_classify.sv]
// ----------------------------------------------------------------------------
// jsc_classify
// Decodes one input byte into the character classes the parser tests.
// ----------------------------------------------------------------------------
`default_nettype none

module jsc_classify (
    input  wire logic [7:0]           char_byte,
    output jsc_pkg::char_class_t      char_class
);

    logic is_digit;
    logic is_letter;

    assign is_digit  = (char_byte >= jsc_pkg::CHAR_ZERO) && (char_byte <= jsc_pkg::CHAR_NINE);
    assign is_letter = ((char_byte >= jsc_pkg::CHAR_LC_A) && (char_byte <= jsc_pkg::CHAR_LC_Z))
                    || ((char_byte >= jsc_pkg::CHAR_UC_A) && (char_byte <= jsc_pkg::CHAR_UC_Z));

    always_comb begin
        char_class.is_ws    = (char_byte == jsc_pkg::CHAR_SPACE)
                           || ((char_byte >= jsc_pkg::CHAR_TAB)
                               && (char_byte <= jsc_pkg::CHAR_CR));
        char_class.is_digit = is_digit;
        char_class.is_alnum = is_digit || is_letter;
        char_class.is_open  = (char_byte == jsc_pkg::CHAR_OPEN);
        char_class.is_close = (char_byte == jsc_pkg::CHAR_CLOSE);
        char_class.is_colon = (char_byte == jsc_pkg::CHAR_COLON);
        char_class.is_comma = (char_byte == jsc_pkg::CHAR_COMMA);
        char_class.is_quote = (char_byte == jsc_pkg::CHAR_QUOTE);
        char_class.is_n     = (char_byte == jsc_pkg::CHAR_N);
        char_class.is_u     = (char_byte == jsc_pkg::CHAR_U);
        char_class.is_l     = (char_byte == jsc_pkg::CHAR_L);
    end

endmodule

`default_nettype wire

[rtl/jsc_parser.sv]
// ----------------------------------------------------------------------------
// jsc_parser
// Parse state, one transition per beat, and the registered verdict output.
// ----------------------------------------------------------------------------
`default_nettype none

module jsc_parser #(
    parameter int unsigned DEPTH_BITS    = 8,
    parameter int unsigned POSITION_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   item_fire,
    input  wire logic                   item_last,
    input  wire jsc_pkg::char_class_t   char_class,
    input  wire logic [7:0]             max_nesting,
    input  wire logic                   m_tready,
    output logic                        m_tvalid,
    output jsc_pkg::verdict_t           verdict,
    output logic [jsc_pkg::OUT_POS_BITS-1:0] byte_position
);

    typedef enum logic [3:0] {
        PH_TOP_OPEN    = 4'd0,
        PH_AFTER_OPEN  = 4'd1,
        PH_KEY_STR     = 4'd2,
        PH_COLON       = 4'd3,
        PH_VALUE       = 4'd4,
        PH_VAL_STR     = 4'd5,
        PH_NUMBER      = 4'd6,
        PH_NULL        = 4'd7,
        PH_NULL_END    = 4'd8,
        PH_AFTER_VALUE = 4'd9,
        PH_NEXT_KEY    = 4'd10
    } phase_t;

    localparam logic [DEPTH_BITS-1:0]    DEPTH_MAX = {DEPTH_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_MAX   = {POSITION_BITS{1'b1}};
    localparam int unsigned LVL_CMP_BITS = (DEPTH_BITS > 8) ? DEPTH_BITS : 8;
    localparam int unsigned POS_EXT_BITS = (POSITION_BITS > jsc_pkg::OUT_POS_BITS)
                                         ? POSITION_BITS : jsc_pkg::OUT_POS_BITS;
    localparam logic [POS_EXT_BITS-1:0]  OUT_POS_MAX =
        POS_EXT_BITS'({jsc_pkg::OUT_POS_BITS{1'b1}});

    phase_t                     phase_reg,     phase_next;
    logic [DEPTH_BITS-1:0]      level_reg,     level_next;
    logic [1:0]                 null_idx_reg,  null_idx_next;
    logic [POSITION_BITS-1:0]   seen_reg,      seen_next;
    logic                       given_reg,     given_next;
    logic                       out_valid_reg, out_valid_next;
    jsc_pkg::verdict_t          verdict_reg,   verdict_next;
    logic [jsc_pkg::OUT_POS_BITS-1:0] pos_reg, pos_next;

    logic                       give;
    jsc_pkg::verdict_t          give_code;
    logic [POSITION_BITS-1:0]   give_pos;
    logic                       do_open;
    logic                       do_close;
    logic                       do_after;
    logic                       too_deep;
    logic [POS_EXT_BITS-1:0]    give_pos_ext;

    assign too_deep = (LVL_CMP_BITS'(level_reg) >= LVL_CMP_BITS'(max_nesting))
                   || (level_reg == DEPTH_MAX);
    assign give_pos_ext = POS_EXT_BITS'(give_pos);

    always_comb begin
        phase_next    = phase_reg;
        level_next    = level_reg;
        null_idx_next = null_idx_reg;
        seen_next     = seen_reg;
        given_next    = given_reg;
        give          = 1'b0;
        give_code     = jsc_pkg::VERDICT_UNEXPECTED;
        give_pos      = seen_reg;
        do_open       = 1'b0;
        do_close      = 1'b0;
        do_after      = 1'b0;

        if (item_fire && item_last) begin
            if (!given_reg) begin
                give      = 1'b1;
                give_code = jsc_pkg::VERDICT_EARLY_END;
            end
        end else if (item_fire && !given_reg) begin
            unique case (phase_reg)
                PH_TOP_OPEN: begin
                    if (char_class.is_ws) begin
                    end else if (char_class.is_open) begin
                        do_open = 1'b1;
                    end else begin
                        give = 1'b1;
                    end
                end
                PH_AFTER_OPEN: begin
                    if (char_class.is_ws) begin
                    end else if (char_class.is_close) begin
                        do_close = 1'b1;
                    end else if (char_class.is_quote) begin
                        phase_next = PH_KEY_STR;
                    end else begin
                        give = 1'b1;
                    end
                end
                PH_NEXT_KEY: begin
                    if (char_class.is_ws) begin
                    end else if (char_class.is_quote) begin
                        phase_next = PH_KEY_STR;
                    end else begin
                        give = 1'b1;
                    end
                end
                PH_KEY_STR: begin
                    if (char_class.is_quote) begin
                        phase_next = PH_COLON;
                    end
                end
                PH_COLON: begin
                    if (char_class.is_ws) begin
                    end else if (char_class.is_colon) begin
                        phase_next = PH_VALUE;
                    end else begin
                        give = 1'b1;
                    end
                end
                PH_VALUE: begin
                    if (char_class.is_ws) begin
                    end else if (char_class.is_quote) begin
                        phase_next = PH_VAL_STR;
                    end else if (char_class.is_digit) begin
                        phase_next = PH_NUMBER;
                    end else if (char_class.is_open) begin
                        do_open = 1'b1;
                    end else if (char_class.is_n) begin
                        phase_next    = PH_NULL;
                        null_idx_next = 2'd0;
                    end else begin
                        give = 1'b1;
                    end
                end
                PH_VAL_STR: begin
                    if (char_class.is_quote) begin
                        phase_next = PH_AFTER_VALUE;
                    end
                end
                PH_NUMBER: begin
                    if (!char_class.is_digit) begin
                        do_after = 1'b1;
                    end
                end
                PH_NULL: begin
                    if ((null_idx_reg == 2'd0) ? !char_class.is_u : !char_class.is_l) begin
                        give = 1'b1;
                    end else if (null_idx_reg >= 2'd2) begin
                        null_idx_next = 2'd0;
                        phase_next    = PH_NULL_END;
                    end else begin
                        null_idx_next = null_idx_reg + 2'd1;
                    end
                end
                PH_NULL_END: begin
                    if (char_class.is_alnum) begin
                        give = 1'b1;
                    end else begin
                        do_after = 1'b1;
                    end
                end
                default: begin
                    do_after = 1'b1;
                end
            endcase

            if (do_after) begin
                phase_next = PH_AFTER_VALUE;
                if (char_class.is_ws) begin
                end else if (char_class.is_comma) begin
                    phase_next = PH_NEXT_KEY;
                end else if (char_class.is_close) begin
                    do_close = 1'b1;
                end else begin
                    give = 1'b1;
                end
            end

            if (do_open) begin
                if (too_deep) begin
                    give      = 1'b1;
                    give_code = jsc_pkg::VERDICT_TOO_DEEP;
                end else begin
                    level_next = level_reg + 1'b1;
                    phase_next = PH_AFTER_OPEN;
                end
            end

            if (do_close) begin
                if (level_reg != '0) begin
                    level_next = level_reg - 1'b1;
                end
                if (level_reg <= DEPTH_BITS'(1)) begin
                    give      = 1'b1;
                    give_code = jsc_pkg::VERDICT_ACCEPTED;
                    give_pos  = (seen_reg == POS_MAX) ? POS_MAX : seen_reg + 1'b1;
                end else begin
                    phase_next = PH_AFTER_VALUE;
                end
            end

            if (give) begin
                given_next = 1'b1;
            end else if (seen_reg != POS_MAX) begin
                seen_next = seen_reg + 1'b1;
            end
        end

        if (item_fire && item_last) begin
            phase_next    = PH_TOP_OPEN;
            level_next    = '0;
            null_idx_next = 2'd0;
            seen_next     = '0;
            given_next    = 1'b0;
        end

        out_valid_next = give ? 1'b1 : (out_valid_reg && !m_tready);
        verdict_next   = give ? give_code : verdict_reg;
        pos_next       = pos_reg;
        if (give) begin
            pos_next = (give_pos_ext > OUT_POS_MAX) ? OUT_POS_MAX[jsc_pkg::OUT_POS_BITS-1:0]
                                                    : give_pos_ext[jsc_pkg::OUT_POS_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_TOP_OPEN;
            level_reg     <= '0;
            null_idx_reg  <= 2'd0;
            seen_reg      <= '0;
            given_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            verdict_reg   <= jsc_pkg::VERDICT_ACCEPTED;
            pos_reg       <= '0;
        end else begin
            phase_reg     <= phase_next;
            level_reg     <= level_next;
            null_idx_reg  <= null_idx_next;
            seen_reg      <= seen_next;
            given_reg     <= given_next;
            out_valid_reg <= out_valid_next;
            verdict_reg   <= verdict_next;
            pos_reg       <= pos_next;
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign verdict       = verdict_reg;
    assign byte_position = pos_reg;

endmodule

`default_nettype wire

[dv/tb_json_object_syntax_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_object_syntax_checker
// Self-checking testbench of the streaming JSON object syntax checker.
// ----------------------------------------------------------------------------
// A short table of directed beats covers the verdict codes, the byte extremes
// and the behaviour around end of document. Random documents follow under
// several nesting limits. Most of them are well formed, and the rest are
// truncated, corrupted, padded, empty or pure noise. Every result beat is
// compared with a predictor that tracks the parse state beat by beat. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module tb_json_object_syntax_checker;

    localparam int ITEMS         = 650;
    localparam int PHASES        = 5;
    localparam int DRAIN_CYCLES  = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam logic [15:0] POS_SAT = 16'hFFFF;

    typedef enum logic [3:0] {
        P_TOP, P_OPEN, P_KEY, P_COLON, P_VALUE, P_VSTR,
        P_NUM, P_NULL, P_NULL_END, P_AFTER, P_NEXT
    } parse_phase_t;

    typedef struct packed {
        logic              cfg;
        logic [7:0]        data;
        logic              last;
        logic              typed;
        jsc_pkg::verdict_t v;
        logic [15:0]       pos;
    } beat_row_t;

    typedef struct packed {
        jsc_pkg::verdict_t v;
        logic [15:0]       pos;
    } verdict_rec_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;   // [7:0] char_byte
    logic        s_tlast   = 1'b0;    // end_of_input
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;             // [1:0] verdict, [17:2] byte_position
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = 8'h00;   // [7:0] max_nesting

    parse_phase_t ph;
    logic [7:0]   lvl;
    logic [1:0]   null_idx;
    logic [15:0]  seen;
    logic         done;
    logic [7:0]   nest_limit;

    verdict_rec_t verdict_q[$];
    beat_row_t    pending_rows[$];
    beat_row_t    directed_rows[$];
    logic [7:0]   doc_bytes[$];
    int           mismatches = 0;
    bit           calm = 1'b0;
    int           rdy_left = 0;

    json_object_syntax_checker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic bit is_ws(input logic [7:0] c);
        return c == jsc_pkg::CHAR_SPACE || (c >= jsc_pkg::CHAR_TAB && c <= jsc_pkg::CHAR_CR);
    endfunction

    function automatic bit is_dig(input logic [7:0] c);
        return c >= jsc_pkg::CHAR_ZERO && c <= jsc_pkg::CHAR_NINE;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= jsc_pkg::CHAR_LC_A && c <= jsc_pkg::CHAR_LC_Z) ||
               (c >= jsc_pkg::CHAR_UC_A && c <= jsc_pkg::CHAR_UC_Z);
    endfunction

    function automatic void clear_parse();
        ph       = P_TOP;
        lvl      = '0;
        null_idx = '0;
        seen     = '0;
        done     = 1'b0;
    endfunction

    function automatic void predict_beat(input logic [7:0] c, input logic eoi,
                                         output logic hit, output jsc_pkg::verdict_t v,
                                         output logic [15:0] pos);
        bit bad, deep, open_req, close_req, after_req;
        logic [7:0] want_c;
        bad = 0; deep = 0; open_req = 0; close_req = 0; after_req = 0;
        hit = 1'b0;
        v   = jsc_pkg::VERDICT_ACCEPTED;
        pos = '0;
        if (eoi) begin
            if (!done) begin
                hit = 1'b1;
                v   = jsc_pkg::VERDICT_EARLY_END;
                pos = seen;
            end
            clear_parse();
            return;
        end
        if (done)
            return;
        case (ph)
            P_TOP: begin
                if (c == jsc_pkg::CHAR_OPEN) open_req = 1;
                else if (!is_ws(c)) bad = 1;
            end
            P_OPEN: begin
                if (c == jsc_pkg::CHAR_CLOSE) close_req = 1;
                else if (c == jsc_pkg::CHAR_QUOTE) ph = P_KEY;
                else if (!is_ws(c)) bad = 1;
            end
            P_NEXT: begin
                if (c == jsc_pkg::CHAR_QUOTE) ph = P_KEY;
                else if (!is_ws(c)) bad = 1;
            end
            P_KEY: begin
                if (c == jsc_pkg::CHAR_QUOTE) ph = P_COLON;
            end
            P_COLON: begin
                if (c == jsc_pkg::CHAR_COLON) ph = P_VALUE;
                else if (!is_ws(c)) bad = 1;
            end
            P_VALUE: begin
                if (c == jsc_pkg::CHAR_QUOTE) ph = P_VSTR;
                else if (is_dig(c)) ph = P_NUM;
                else if (c == jsc_pkg::CHAR_OPEN) open_req = 1;
                else if (c == jsc_pkg::CHAR_N) begin
                    ph = P_NULL;
                    null_idx = '0;
                end else if (!is_ws(c)) bad = 1;
            end
            P_VSTR: begin
                if (c == jsc_pkg::CHAR_QUOTE) ph = P_AFTER;
            end
            P_NUM: begin
                if (!is_dig(c)) after_req = 1;
            end
            P_NULL: begin
                want_c = (null_idx == 2'd0) ? jsc_pkg::CHAR_U : jsc_pkg::CHAR_L;
                if (c != want_c) bad = 1;
                else if (null_idx >= 2'd2) begin
                    null_idx = '0;
                    ph = P_NULL_END;
                end else null_idx++;
            end
            P_NULL_END: begin
                if (is_dig(c) || is_letter(c)) bad = 1;
                else after_req = 1;
            end
            default: after_req = 1;
        endcase
        if (after_req) begin
            ph = P_AFTER;
            if (c == jsc_pkg::CHAR_COMMA) ph = P_NEXT;
            else if (c == jsc_pkg::CHAR_CLOSE) close_req = 1;
            else if (!is_ws(c)) bad = 1;
        end
        if (open_req) begin
            if (lvl >= nest_limit) deep = 1;
            else begin
                lvl++;
                ph = P_OPEN;
            end
        end
        if (close_req) begin
            if (lvl != 8'd0) lvl--;
            if (lvl == 8'd0) begin
                hit = 1'b1;
                v   = jsc_pkg::VERDICT_ACCEPTED;
                pos = (seen != POS_SAT) ? seen + 16'd1 : seen;
            end else ph = P_AFTER;
        end
        if (bad || deep) begin
            hit = 1'b1;
            v   = bad ? jsc_pkg::VERDICT_UNEXPECTED : jsc_pkg::VERDICT_TOO_DEEP;
            pos = seen;
        end
        if (hit) done = 1'b1;
        else if (seen != POS_SAT) seen++;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 40)
            $display("MISMATCH %s: got %0d, expected %0d at %0t ns", what, got, want, $time);
        mismatches++;
    endtask

    always @(posedge aclk) begin : monitor
        beat_row_t         row;
        logic              hit;
        jsc_pkg::verdict_t v;
        logic [15:0]       pos;
        verdict_rec_t      want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                nest_limit = cfg_data;
            if (s_tvalid && s_tready) begin
                row = (pending_rows.size() != 0) ? pending_rows.pop_front() : '0;
                predict_beat(s_tdata, s_tlast, hit, v, pos);
                if (row.typed) begin
                    hit = 1'b1;
                    v   = row.v;
                    pos = row.pos;
                end
                if (hit)
                    verdict_q.push_back('{v: v, pos: pos});
            end
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected", m_tdata, 0);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[1:0] !== want.v)
                        report_mismatch("verdict", m_tdata[1:0], want.v);
                    if (m_tdata[17:2] !== want.pos)
                        report_mismatch("byte_position", m_tdata[17:2], want.pos);
                    if (m_tdata[23:18] !== 6'd0)
                        report_mismatch("padding bits", m_tdata[23:18], 0);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (rdy_left != 0) begin
            rdy_left <= rdy_left - 1;
        end else if (calm || $urandom_range(0, 1) == 0) begin
            m_tready <= 1'b1;
            rdy_left <= $urandom_range(0, 15);
        end else begin
            m_tready <= 1'b0;
            rdy_left <= pick_gap();
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_beat(input beat_row_t row);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row.data;
        s_tlast  <= row.last;
        pending_rows.push_back(row);
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_limit(input logic [7:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic beat_row_t beat(input logic [7:0] c, input logic last);
        return '{cfg: 1'b0, data: c, last: last, typed: 1'b0,
                 v: jsc_pkg::VERDICT_ACCEPTED, pos: '0};
    endfunction

    function automatic beat_row_t beat_with(input logic [7:0] c, input logic last,
                                            input jsc_pkg::verdict_t v,
                                            input logic [15:0] pos);
        return '{cfg: 1'b0, data: c, last: last, typed: 1'b1, v: v, pos: pos};
    endfunction

    function automatic logic [7:0] ws_char();
        case ($urandom_range(0, 3))
            0: return jsc_pkg::CHAR_SPACE;
            1: return jsc_pkg::CHAR_TAB;
            2: return jsc_pkg::CHAR_CR;
            default: return 8'($urandom_range(10, 12));
        endcase
    endfunction

    function automatic void add_ws();
        if ($urandom_range(0, 3) == 0)
            doc_bytes.push_back(ws_char());
    endfunction

    function automatic void add_text();
        logic [7:0] c;
        doc_bytes.push_back(jsc_pkg::CHAR_QUOTE);
        repeat ($urandom_range(0, 4)) begin
            c = 8'($urandom_range(0, 255));
            doc_bytes.push_back(c == jsc_pkg::CHAR_QUOTE ? 8'h27 : c);
        end
        doc_bytes.push_back(jsc_pkg::CHAR_QUOTE);
    endfunction

    function automatic void build_doc(input int deepest);
        int  lvl_now, members, pick;
        bit  fresh;
        doc_bytes.delete();
        add_ws();
        doc_bytes.push_back(jsc_pkg::CHAR_OPEN);
        lvl_now = 1;
        fresh   = 1;
        members = $urandom_range(0, 8);
        while (lvl_now > 0) begin
            if (members == 0 || $urandom_range(0, 3) == 0) begin
                add_ws();
                doc_bytes.push_back(jsc_pkg::CHAR_CLOSE);
                lvl_now--;
                fresh = 0;
            end else begin
                members--;
                if (!fresh) begin
                    add_ws();
                    doc_bytes.push_back(jsc_pkg::CHAR_COMMA);
                end
                add_ws();
                add_text();
                add_ws();
                doc_bytes.push_back(jsc_pkg::CHAR_COLON);
                add_ws();
                pick  = $urandom_range(0, 3);
                fresh = 0;
                if (pick == 0 && lvl_now < deepest) begin
                    doc_bytes.push_back(jsc_pkg::CHAR_OPEN);
                    lvl_now++;
                    fresh = 1;
                end else if (pick == 1) begin
                    add_text();
                end else if (pick == 2) begin
                    repeat ($urandom_range(1, 3))
                        doc_bytes.push_back(
                            8'($urandom_range(jsc_pkg::CHAR_ZERO, jsc_pkg::CHAR_NINE)));
                end else begin
                    doc_bytes.push_back(jsc_pkg::CHAR_N);
                    doc_bytes.push_back(jsc_pkg::CHAR_U);
                    doc_bytes.push_back(jsc_pkg::CHAR_L);
                    doc_bytes.push_back(jsc_pkg::CHAR_L);
                end
            end
        end
        add_ws();
    endfunction

    task automatic send_doc_bytes();
        foreach (doc_bytes[i])
            send_beat(beat(doc_bytes[i], 1'b0));
        send_beat(beat(8'($urandom_range(0, 255)), 1'b1));
    endtask

    task automatic send_doc(input int lim, inout int counted);
        int deepest, kind, cut, useful;
        deepest = ($urandom_range(0, 3) == 0) ? lim + 1 : lim;
        if (deepest > 5) deepest = 5;
        build_doc(deepest);
        useful = doc_bytes.size();
        kind   = $urandom_range(0, 11);
        calm   = ($urandom_range(0, 4) == 0);
        if (kind == 0) begin
            doc_bytes.delete();
            if ($urandom_range(0, 1) == 0) doc_bytes.push_back(jsc_pkg::CHAR_OPEN);
            repeat ($urandom_range(1, 8)) doc_bytes.push_back(8'($urandom_range(0, 255)));
            useful = doc_bytes.size();
        end else if (kind == 1) begin
            cut = $urandom_range(0, doc_bytes.size() - 1);
            doc_bytes = doc_bytes[0:cut];
            useful = doc_bytes.size();
        end else if (kind == 2) begin
            cut = $urandom_range(0, doc_bytes.size() - 1);
            doc_bytes[cut] = 8'($urandom_range(0, 255));
            useful = cut + 1;
            if (cut + 2 < doc_bytes.size())
                doc_bytes = doc_bytes[0:cut + 2];
        end else if (kind == 3) begin
            repeat ($urandom_range(1, 3)) doc_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (kind == 4) begin
            doc_bytes.delete();
            useful = 0;
        end
        send_doc_bytes();
        counted += useful + 1;
    endtask

    initial begin : stimulus
        logic [7:0] limits[PHASES];
        int         counted;
        clear_parse();
        nest_limit = 8'd255;
        limits = '{8'd1, 8'd2, 8'd3, 8'($urandom_range(4, 254)), 8'd255};
        directed_rows = '{
            beat(jsc_pkg::CHAR_OPEN, 1'b0),
            beat_with(jsc_pkg::CHAR_CLOSE, 1'b0, jsc_pkg::VERDICT_ACCEPTED, 16'd2),
            beat(8'hFF, 1'b0),
            beat(8'h00, 1'b1),
            beat_with(8'hFF, 1'b1, jsc_pkg::VERDICT_EARLY_END, 16'd0),
            beat_with(8'h00, 1'b0, jsc_pkg::VERDICT_UNEXPECTED, 16'd0),
            beat(8'h00, 1'b1),
            beat(jsc_pkg::CHAR_OPEN, 1'b0),
            beat_with(8'h00, 1'b1, jsc_pkg::VERDICT_EARLY_END, 16'd1),
            beat(jsc_pkg::CHAR_SPACE, 1'b0),
            beat(jsc_pkg::CHAR_OPEN, 1'b0),
            beat(jsc_pkg::CHAR_QUOTE, 1'b0),
            beat(8'h00, 1'b0),
            beat(8'hFF, 1'b0),
            beat(jsc_pkg::CHAR_QUOTE, 1'b0),
            beat(jsc_pkg::CHAR_COLON, 1'b0),
            beat(jsc_pkg::CHAR_N, 1'b0),
            beat(jsc_pkg::CHAR_U, 1'b0),
            beat(jsc_pkg::CHAR_L, 1'b0),
            beat(jsc_pkg::CHAR_L, 1'b0),
            beat_with(jsc_pkg::CHAR_ZERO, 1'b0, jsc_pkg::VERDICT_UNEXPECTED, 16'd11),
            beat(8'h00, 1'b1),
            '{cfg: 1'b1, data: 8'd1, last: 1'b0, typed: 1'b0,
              v: jsc_pkg::VERDICT_ACCEPTED, pos: '0},
            beat(jsc_pkg::CHAR_OPEN, 1'b0),
            beat(jsc_pkg::CHAR_QUOTE, 1'b0),
            beat(jsc_pkg::CHAR_QUOTE, 1'b0),
            beat(jsc_pkg::CHAR_COLON, 1'b0),
            beat_with(jsc_pkg::CHAR_OPEN, 1'b0, jsc_pkg::VERDICT_TOO_DEEP, 16'd4),
            beat(8'h00, 1'b1)
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].cfg) write_limit(directed_rows[i].data);
            else send_beat(directed_rows[i]);
        end

        foreach (limits[p]) begin
            write_limit(limits[p]);
            counted = 0;
            while (counted < ITEMS / PHASES)
                send_doc(limits[p], counted);
        end

        s_tvalid <= 1'b0;
        calm = 1'b0;
        @(posedge aclk);
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (verdict_q.size() != 0)
            report_mismatch("expected results left over", verdict_q.size(), 0);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
rtl/jsc_pkg.sv
rtl/jsc_classify.sv
rtl/jsc_parser.sv
rtl/json_object_syntax_checker.sv
dv/tb_json_object_syntax_checker.sv
